// ===== rtl/bdll_pkg.sv =====
// ----------------------------------------------------------------------------
// bdll_pkg: types and constants for the bounded doubly linked list
// Request and response payloads, operation and status codes.
// ----------------------------------------------------------------------------
package bdll_pkg;

   localparam int unsigned CAPACITY = 256;
   localparam int unsigned IDX_W    = 8;
   localparam int unsigned LINK_W   = 9;
   localparam logic [LINK_W-1:0] NIL = LINK_W'(CAPACITY);

   typedef enum logic [2:0] {
      OP_INS_FRONT = 3'd0,
      OP_INS_BACK  = 3'd1,
      OP_INS_POS   = 3'd2,
      OP_DEL_FRONT = 3'd3,
      OP_DEL_BACK  = 3'd4,
      OP_DEL_AFTER = 3'd5,
      OP_SEARCH    = 3'd6,
      OP_NONE      = 3'd7
   } op_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_FULL      = 3'd1,
      ST_EMPTY     = 3'd2,
      ST_SHORT     = 3'd3,
      ST_NOT_FOUND = 3'd4
   } status_type;

   typedef struct packed {
      logic [2:0]         req_type;
      logic [8:0]         position;
      logic signed [31:0] value;
   } req_type_type;

   typedef struct packed {
      logic [2:0]         status;
      logic signed [31:0] result_value;
      logic [8:0]         found_position;
      logic [8:0]         list_length;
   } rsp_type;

endpackage

// ===== rtl/bounded_doubly_linked_list.sv =====
// ----------------------------------------------------------------------------
// bounded_doubly_linked_list: ordered list of signed values in a node pool
// Node value, links and free stack live in synchronous memories.
// ----------------------------------------------------------------------------
// One request at a time. Front/back inserts and deletes pass through their
// allocate and link, or unlink, states before the response; a request that
// ends at once (full, empty, short list, unused code) goes straight to it.
// Insert after position, delete after value and search walk the list node
// by node (link memory read, then compare). The response sits in an output
// register; the next request is taken in the cycle after it has been
// transferred.
module bounded_doubly_linked_list (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  bdll_pkg::req_type_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output bdll_pkg::rsp_type     rsp_data
);

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_ALLOC = 9'b000000010,
      S_WALK  = 9'b000000100,
      S_WCHK  = 9'b000001000,
      S_LINK  = 9'b000010000,
      S_ULRD  = 9'b000100000,
      S_ULWR  = 9'b001000000,
      S_MRD   = 9'b010000000,
      S_RESP  = 9'b100000000
   } state_type;

   localparam int unsigned LW = bdll_pkg::LINK_W;
   localparam int unsigned IW = bdll_pkg::IDX_W;

   // memories
   logic signed [31:0] val_mem  [bdll_pkg::CAPACITY];
   logic [LW-1:0]      next_mem [bdll_pkg::CAPACITY];
   logic [LW-1:0]      prev_mem [bdll_pkg::CAPACITY];
   logic [IW-1:0]      free_mem [bdll_pkg::CAPACITY];

   state_type state_ff;
   logic [LW-1:0] head_ff, tail_ff, count_ff, bump_ff, ftop_ff;
   bdll_pkg::req_type_type req_ff;
   logic [LW-1:0] node_ff;   // node being allocated or unlinked
   logic [LW-1:0] cur_ff;    // walk cursor
   logic [LW-1:0] step_ff;   // steps taken / 1-based position
   logic [LW-1:0] pred_ff;   // link target for insert
   logic [2:0] st_ff;
   logic signed [31:0] rv_ff;
   logic [LW-1:0] fp_ff;
   logic rsp_valid_ff;
   bdll_pkg::rsp_type rsp_ff;

   // registered read data
   logic signed [31:0] rd_val;
   logic [LW-1:0] rd_next, rd_prev;
   logic [IW-1:0] rd_free;
   logic [IW-1:0] rd_addr;
   logic [IW-1:0] free_rd_addr;

   // one write port per memory, driven from the control logic
   logic wv_en, wn_en, wp_en, wf_en;
   logic [IW-1:0] wv_addr, wn_addr, wp_addr, wf_addr;
   logic signed [31:0] wv_data;
   logic [LW-1:0] wn_data, wp_data;
   logic [IW-1:0] wf_data;

   always_ff @(posedge clock) begin
      if (wv_en) val_mem[wv_addr] <= wv_data;
      if (wn_en) next_mem[wn_addr] <= wn_data;
      if (wp_en) prev_mem[wp_addr] <= wp_data;
      if (wf_en) free_mem[wf_addr] <= wf_data;
      rd_val  <= val_mem[rd_addr];
      rd_next <= next_mem[rd_addr];
      rd_prev <= prev_mem[rd_addr];
      rd_free <= free_mem[free_rd_addr];
   end

   // second link writes (neighbour fix-up) go in a following cycle
   logic [LW-1:0] fix_n_ff, fix_p_ff; // neighbours captured at link or unlink
   logic phase_ff;

   logic req_x, rsp_x;
   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign req_x = req_valid && req_ready;
   assign rsp_x = rsp_valid_ff && rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   logic full_c;
   assign full_c = (count_ff == LW'(bdll_pkg::CAPACITY));

   // read address selection
   always_comb begin
      rd_addr = cur_ff[IW-1:0];
      free_rd_addr = IW'(ftop_ff - LW'(1));
      if (state_ff == S_ULRD || state_ff == S_LINK) rd_addr = node_ff[IW-1:0];
      if (state_ff == S_LINK) rd_addr = pred_ff[IW-1:0];
   end

   logic [LW-1:0] nx_c;
   assign nx_c = (pred_ff == bdll_pkg::NIL) ? head_ff : rd_next;

   always_comb begin
      wv_en = 1'b0; wn_en = 1'b0; wp_en = 1'b0; wf_en = 1'b0;
      wv_addr = node_ff[IW-1:0]; wv_data = req_ff.value;
      wn_addr = node_ff[IW-1:0]; wn_data = nx_c;
      wp_addr = node_ff[IW-1:0]; wp_data = pred_ff;
      wf_addr = ftop_ff[IW-1:0]; wf_data = node_ff[IW-1:0];
      case (state_ff)
         S_LINK: begin
            if (phase_ff) begin
               // write new node and its links
               wv_en = 1'b1; wn_en = 1'b1; wp_en = 1'b1;
            end else begin
               // neighbour fix-up: prev.next = x, next.prev = x
               wn_en = (pred_ff != bdll_pkg::NIL);
               wn_addr = pred_ff[IW-1:0]; wn_data = node_ff;
               wp_en = (fix_n_ff != bdll_pkg::NIL);
               wp_addr = fix_n_ff[IW-1:0]; wp_data = node_ff;
            end
         end
         S_ULWR: begin
            wn_en = (fix_p_ff != bdll_pkg::NIL);
            wn_addr = fix_p_ff[IW-1:0]; wn_data = fix_n_ff;
            wp_en = (fix_n_ff != bdll_pkg::NIL);
            wp_addr = fix_n_ff[IW-1:0]; wp_data = fix_p_ff;
            wf_en = (ftop_ff != LW'(bdll_pkg::CAPACITY));
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff <= bdll_pkg::NIL;
         tail_ff <= bdll_pkg::NIL;
         count_ff <= '0; bump_ff <= '0; ftop_ff <= '0;
         rsp_valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         if (rsp_x) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req_x) begin
                  req_ff <= req_data;
                  st_ff <= bdll_pkg::ST_OK;
                  rv_ff <= '0; fp_ff <= '0;
                  // back insert reads the tail's link while allocating
                  cur_ff <= (req_data.req_type == bdll_pkg::OP_INS_BACK) ? tail_ff : head_ff;
                  step_ff <= LW'(1);
                  case (bdll_pkg::op_type'(req_data.req_type))
                     bdll_pkg::OP_INS_FRONT, bdll_pkg::OP_INS_BACK,
                     bdll_pkg::OP_INS_POS: begin
                        if (full_c) begin
                           st_ff <= bdll_pkg::ST_FULL; state_ff <= S_RESP;
                        end else if (req_data.req_type == bdll_pkg::OP_INS_POS
                                     && req_data.position > count_ff) begin
                           st_ff <= bdll_pkg::ST_SHORT; state_ff <= S_RESP;
                        end else begin
                           state_ff <= S_ALLOC;
                        end
                     end
                     bdll_pkg::OP_DEL_FRONT, bdll_pkg::OP_DEL_BACK: begin
                        if (count_ff == '0 || head_ff == bdll_pkg::NIL) begin
                           st_ff <= bdll_pkg::ST_EMPTY; state_ff <= S_RESP;
                        end else begin
                           node_ff <= (req_data.req_type == bdll_pkg::OP_DEL_FRONT)
                                      ? head_ff : tail_ff;
                           state_ff <= S_ULRD; phase_ff <= 1'b0;
                        end
                     end
                     bdll_pkg::OP_DEL_AFTER: begin
                        if (count_ff == '0 || head_ff == bdll_pkg::NIL) begin
                           st_ff <= bdll_pkg::ST_EMPTY; state_ff <= S_RESP;
                        end else state_ff <= S_MRD;
                     end
                     bdll_pkg::OP_SEARCH: begin
                        if (head_ff == bdll_pkg::NIL) begin
                           st_ff <= bdll_pkg::ST_NOT_FOUND; state_ff <= S_RESP;
                        end else state_ff <= S_MRD;
                     end
                     default: state_ff <= S_RESP;
                  endcase
               end
            end
            // take a node: free stack top was read last cycle
            S_ALLOC: begin
               if (ftop_ff != '0) begin
                  node_ff <= {1'b0, rd_free};
                  ftop_ff <= ftop_ff - LW'(1);
               end else begin
                  node_ff <= bump_ff;
                  bump_ff <= bump_ff + LW'(1);
               end
               step_ff <= '0;
               pred_ff <= bdll_pkg::NIL;
               if (req_ff.req_type == bdll_pkg::OP_INS_BACK) begin
                  pred_ff <= tail_ff; state_ff <= S_LINK; phase_ff <= 1'b1;
               end else if (req_ff.req_type == bdll_pkg::OP_INS_FRONT
                            || req_ff.position == '0) begin
                  state_ff <= S_LINK; phase_ff <= 1'b1;
               end else begin
                  cur_ff <= head_ff; state_ff <= S_WALK;
               end
            end
            // positional walk: advance pred until pos steps done
            S_WALK: begin
               pred_ff <= cur_ff;
               step_ff <= step_ff + LW'(1);
               state_ff <= S_WCHK;
            end
            S_WCHK: begin
               if (step_ff == req_ff.position) begin
                  state_ff <= S_LINK; phase_ff <= 1'b1;
               end else begin
                  cur_ff <= rd_next; state_ff <= S_WALK;
               end
            end
            // phase 1: pred.next read is valid (addr held), write node
            S_LINK: begin
               if (phase_ff) begin
                  if (pred_ff == bdll_pkg::NIL) head_ff <= node_ff;
                  if (nx_c == bdll_pkg::NIL) tail_ff <= node_ff;
                  fix_n_ff <= nx_c;
                  phase_ff <= 1'b0;
               end else begin
                  count_ff <= count_ff + LW'(1);
                  rv_ff <= req_ff.value;
                  state_ff <= S_RESP;
               end
            end
            S_ULRD: begin
               if (phase_ff) begin
                  fix_n_ff <= rd_next; fix_p_ff <= rd_prev;
                  rv_ff <= rd_val;
                  state_ff <= S_ULWR;
               end else phase_ff <= 1'b1;
            end
            S_ULWR: begin
               if (fix_p_ff == bdll_pkg::NIL) head_ff <= fix_n_ff;
               if (fix_n_ff == bdll_pkg::NIL) tail_ff <= fix_p_ff;
               if (ftop_ff != LW'(bdll_pkg::CAPACITY)) ftop_ff <= ftop_ff + LW'(1);
               count_ff <= count_ff - LW'(1);
               state_ff <= S_RESP;
            end
            // match walk: cur is read in phase 0, its data compared in phase 1
            S_MRD: begin
               if (phase_ff) begin
                  phase_ff <= 1'b0;
                  if (rd_val == req_ff.value) begin
                     if (req_ff.req_type == bdll_pkg::OP_SEARCH) begin
                        fp_ff <= step_ff; state_ff <= S_RESP;
                     end else if (rd_next == bdll_pkg::NIL) begin
                        st_ff <= bdll_pkg::ST_NOT_FOUND; state_ff <= S_RESP;
                     end else begin
                        node_ff <= rd_next; state_ff <= S_ULRD;
                     end
                  end else if (rd_next == bdll_pkg::NIL) begin
                     st_ff <= bdll_pkg::ST_NOT_FOUND; state_ff <= S_RESP;
                  end else begin
                     cur_ff <= rd_next; step_ff <= step_ff + LW'(1);
                  end
               end else phase_ff <= 1'b1;
            end
            S_RESP: begin
               rsp_ff.status <= st_ff;
               rsp_ff.result_value <= rv_ff;
               rsp_ff.found_position <= fp_ff;
               rsp_ff.list_length <= count_ff;
               rsp_valid_ff <= 1'b1;
               phase_ff <= 1'b0;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // assertions
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= LW'(bdll_pkg::CAPACITY)) else $error("count overflow");
   a_empty_links: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && count_ff == '0)
      |-> (head_ff == bdll_pkg::NIL && tail_ff == bdll_pkg::NIL))
      else $error("empty list with live links");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_x |=> !req_ready) else $error("request taken while busy");
   a_ok_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LINK && !phase_ff) |=> count_ff == $past(count_ff) + LW'(1))
      else $error("insert did not grow list");

endmodule

// ===== tb/sv/tb_bounded_doubly_linked_list.sv =====
// ----------------------------------------------------------------------------
// tb_bounded_doubly_linked_list: self-checking bench for the linked list block
// Directed and random list operations go through a valid/ready request
// channel. A behavioural list model predicts every response. A checker
// process compares each response transfer, field by field, with the oldest
// prediction. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_bounded_doubly_linked_list;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAP         = int'(bdll_pkg::CAPACITY);
   localparam int NULL_LINK   = CAP;
   localparam int CYCLE_LIMIT = 2000000;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   bdll_pkg::req_type_type req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   bdll_pkg::rsp_type      rsp_data;

   bounded_doubly_linked_list DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   // Run length guard
   int cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // List model state
   logic signed [31:0] node_val [CAP];
   int                 fwd_link [CAP];
   int                 back_link[CAP];
   int                 free_nodes[CAP];
   int head_node = NULL_LINK, tail_node = NULL_LINK;
   int list_count = 0, bump_next = 0, free_count = 0;

   bdll_pkg::rsp_type expected_rsp[$];
   int      mismatches = 0;
   int      quiet_req = 0, quiet_rsp = 0;

   // Idle draw: a random idle gap, or none during occasional stretches of no idling
   function automatic int draw_wait(inout int quiet);
      if (quiet == 0 && $urandom_range(0, 15) == 0) quiet = $urandom_range(5, 25);
      if (quiet > 0) begin
         quiet--;
         return 0;
      end
      return $urandom_range(0, 7);
   endfunction

   function automatic void link_node_after(int p, int x);
      int nx;
      nx = (p == NULL_LINK) ? head_node : fwd_link[p];
      back_link[x] = p;
      fwd_link[x]  = nx;
      if (p == NULL_LINK) head_node = x; else fwd_link[p] = x;
      if (nx == NULL_LINK) tail_node = x; else back_link[nx] = x;
      list_count++;
   endfunction

   function automatic logic signed [31:0] unlink_node(int x);
      int p, n;
      p = back_link[x];
      n = fwd_link[x];
      if (p == NULL_LINK) head_node = n; else fwd_link[p] = n;
      if (n == NULL_LINK) tail_node = p; else back_link[n] = p;
      free_nodes[free_count] = x;
      free_count++;
      list_count--;
      return node_val[x];
   endfunction

   // Expected response of one request; updates the model list
   function automatic bdll_pkg::rsp_type predict_list_op(bdll_pkg::req_type_type r);
      bdll_pkg::rsp_type o;
      int      p, x, i;
      o = '0;
      case (r.req_type)
         bdll_pkg::OP_INS_FRONT, bdll_pkg::OP_INS_BACK, bdll_pkg::OP_INS_POS: begin
            if (list_count >= CAP) o.status = bdll_pkg::ST_FULL;
            else if (r.req_type == bdll_pkg::OP_INS_POS && r.position > list_count)
               o.status = bdll_pkg::ST_SHORT;
            else begin
               if (free_count > 0) begin
                  free_count--;
                  x = free_nodes[free_count];
               end else begin
                  x = bump_next;
                  bump_next++;
               end
               node_val[x] = r.value;
               if (r.req_type == bdll_pkg::OP_INS_FRONT) p = NULL_LINK;
               else if (r.req_type == bdll_pkg::OP_INS_BACK) p = tail_node;
               else begin
                  p = NULL_LINK;
                  for (i = 0; i < r.position; i++)
                     p = (p == NULL_LINK) ? head_node : fwd_link[p];
               end
               link_node_after(p, x);
               o.result_value = r.value;
            end
         end
         bdll_pkg::OP_DEL_FRONT, bdll_pkg::OP_DEL_BACK: begin
            if (list_count == 0) o.status = bdll_pkg::ST_EMPTY;
            else o.result_value = unlink_node(
               r.req_type == bdll_pkg::OP_DEL_FRONT ? head_node : tail_node);
         end
         bdll_pkg::OP_DEL_AFTER: begin
            if (list_count == 0) o.status = bdll_pkg::ST_EMPTY;
            else begin
               p = head_node;
               while (p != NULL_LINK && node_val[p] != r.value) p = fwd_link[p];
               if (p == NULL_LINK || fwd_link[p] == NULL_LINK)
                  o.status = bdll_pkg::ST_NOT_FOUND;
               else o.result_value = unlink_node(fwd_link[p]);
            end
         end
         bdll_pkg::OP_SEARCH: begin
            p = head_node;
            i = 1;
            while (p != NULL_LINK && node_val[p] != r.value) begin
               p = fwd_link[p];
               i++;
            end
            if (p == NULL_LINK) o.status = bdll_pkg::ST_NOT_FOUND;
            else o.found_position = 9'(i);
         end
         default: ;
      endcase
      o.list_length = 9'(list_count);
      return o;
   endfunction

   // Value of the element at a random place in the model list
   function automatic logic signed [31:0] listed_value();
      int p, k;
      p = head_node;
      k = $urandom_range(0, list_count - 1);
      repeat (k) p = fwd_link[p];
      return node_val[p];
   endfunction

   function automatic logic signed [31:0] rand_value();
      case ($urandom_range(0, 4))
         0, 1:    return (list_count > 0) ? listed_value() : $urandom;
         2:       return $signed($urandom_range(0, 15)) - 8;
         3:       return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
         default: return $urandom;
      endcase
   endfunction

   // Send one request and record its prediction on transfer
   task automatic send_req(input bdll_pkg::op_type op, input int pos,
                           input logic signed [31:0] val);
      int gap;
      gap = draw_wait(quiet_req);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{op, pos[8:0], val};
      do @(posedge clock); while (!req_ready);
      expected_rsp.push_back(predict_list_op('{op, pos[8:0], val}));
   endtask

   task automatic note_mismatch(input string what, input longint exp_v, input longint act_v);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t mismatch %s: expected %0d, got %0d", $realtime, what, exp_v, act_v);
   endtask

   // Response checker
   initial begin
      bdll_pkg::rsp_type e;
      int      stall;
      @(negedge reset);
      forever begin
         stall = draw_wait(quiet_rsp);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         if (expected_rsp.size() == 0) note_mismatch("unexpected response", 0, 1);
         else begin
            e = expected_rsp.pop_front();
            if (rsp_data.status !== e.status)
               note_mismatch("status", e.status, rsp_data.status);
            if (rsp_data.result_value !== e.result_value)
               note_mismatch("result_value", e.result_value, rsp_data.result_value);
            if (rsp_data.found_position !== e.found_position)
               note_mismatch("found_position", e.found_position, rsp_data.found_position);
            if (rsp_data.list_length !== e.list_length)
               note_mismatch("list_length", e.list_length, rsp_data.list_length);
         end
      end
   end

   // Empty list, unused code, short list, extremes, append, no-match cases
   task automatic test_directed();
      send_req(bdll_pkg::OP_DEL_FRONT, 0, 1);
      send_req(bdll_pkg::OP_DEL_BACK, 0, 1);
      send_req(bdll_pkg::OP_DEL_AFTER, 0, 1);
      send_req(bdll_pkg::OP_SEARCH, 0, 1);
      send_req(bdll_pkg::OP_NONE, 511, -1);
      send_req(bdll_pkg::OP_INS_POS, 1, 5);
      send_req(bdll_pkg::OP_INS_POS, 0, 10);
      send_req(bdll_pkg::OP_INS_FRONT, 0, 32'sh80000000);
      send_req(bdll_pkg::OP_INS_BACK, 0, 32'sh7fffffff);
      send_req(bdll_pkg::OP_INS_POS, 3, 20);
      send_req(bdll_pkg::OP_INS_POS, 2, -3);
      send_req(bdll_pkg::OP_INS_POS, 511, 7);
      send_req(bdll_pkg::OP_SEARCH, 0, 20);
      send_req(bdll_pkg::OP_SEARCH, 0, 32'sh80000000);
      send_req(bdll_pkg::OP_SEARCH, 0, 12345);
      send_req(bdll_pkg::OP_DEL_AFTER, 0, 20);
      send_req(bdll_pkg::OP_DEL_AFTER, 0, 999);
      send_req(bdll_pkg::OP_DEL_AFTER, 0, 32'sh80000000);
      send_req(bdll_pkg::OP_DEL_FRONT, 0, 0);
      send_req(bdll_pkg::OP_DEL_BACK, 0, 0);
      send_req(bdll_pkg::OP_NONE, 0, 0);
   endtask

   // Fill to capacity, hit the full cases, walk a full list, then drain
   task automatic test_fill_and_drain();
      while (list_count < CAP)
         send_req(bdll_pkg::op_type'($urandom_range(0, 2)), $urandom_range(0, list_count),
                  rand_value());
      send_req(bdll_pkg::OP_INS_FRONT, 0, 1);
      send_req(bdll_pkg::OP_INS_BACK, 0, 1);
      send_req(bdll_pkg::OP_INS_POS, 300, 1);
      send_req(bdll_pkg::OP_INS_POS, 256, 1);
      send_req(bdll_pkg::OP_SEARCH, 0, 32'sh12345678);
      send_req(bdll_pkg::OP_SEARCH, 0, listed_value());
      send_req(bdll_pkg::OP_DEL_AFTER, 0, listed_value());
      while (list_count > 0)
         send_req(bdll_pkg::op_type'($urandom_range(3, 5)), 0, rand_value());
      send_req(bdll_pkg::OP_DEL_BACK, 0, 0);
   endtask

   // Random mix, biased towards well-formed operations on short lists
   task automatic test_random(input int n);
      bdll_pkg::op_type op;
      int     pos;
      repeat (n) begin
         op  = bdll_pkg::op_type'($urandom_range(0, 7));
         if (list_count > 24 && $urandom_range(0, 1))
            op = bdll_pkg::op_type'($urandom_range(3, 6));
         pos = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 511)
                                           : $urandom_range(0, list_count);
         send_req(op, pos, rand_value());
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_fill_and_drain();
      test_random(50);
      @(posedge clock);
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0 && expected_rsp.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
